>>> hdl/ltw_pkg.sv
package ltw_pkg;

	// default longest stored word
	localparam int MAX_WORD_LEN_DEF = 31;
	// width of a word length, covers a longest word of up to 31
	localparam int LEN_W = 5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int          RADIX   = 10;
	localparam logic [31:0] INT_TOP = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_TOP = 32'h8000_0000;
	localparam logic [31:0] MAG_SAT = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_CMD,
		KIND_ARG,
		KIND_SUM
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NON_ASCII,
		ST_TOO_MANY,
		ST_TOO_LONG,
		ST_NOT_INT,
		ST_RANGE,
		ST_NEGATIVE
	} status_t;

	typedef enum logic [1:0] {
		SIGN_NONE,
		SIGN_PLUS,
		SIGN_MINUS
	} sign_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WAIT,
		BK_SUM
	} back_state_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  char_out;
		status_t     status;
		logic [1:0]  word_count;
		logic [30:0] number;
		logic        last;
	} out_item_t;

	// one finished line waiting for emission
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] cmd_len;
		logic [LEN_W-1:0] arg_len;
		status_t          status;
		logic [1:0]       word_count;
		logic [30:0]      number;
	} job_t;

endpackage

>>> hdl/line_tokenizer_three_words_core.sv
// line tokenizer: bytes of a text line go in one item each, then an end-of-line item.
// text from the first "//" or a zero byte on is dropped, the rest is split at
// whitespace into up to three words; the first two come out character by character
// (kind 0, then kind 1) followed by one summary item with status, word count and the
// third word parsed as a non-negative 32-bit integer; a line with an error yields
// only its summary. the front takes one byte per cycle while push does not see full; a
// '/' that does not start a comment is handled with the item after it, which is then
// replayed, and the end-of-line item closes the line. the back picks up a finished
// line, then emits each stored character by a ram read then the output register,
// and the summary after the last character. the word ram is split into two banks,
// so the front fills the next line while the back empties the last one; push sees
// full while two finished lines are waiting and while the item that followed a
// lone '/' is replayed
module line_tokenizer_three_words_core #(
	parameter int MAX_WORD_LEN = ltw_pkg::MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ltw_pkg::in_item_t  char_item,
	input  logic               push,
	output logic               full,
	output ltw_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	import ltw_pkg::*;

	// ram address is {bank, word select, char index}
	localparam int IdxW  = $clog2(MAX_WORD_LEN);
	localparam int AddrW = IdxW + 2;
	localparam int Depth = 4 << IdxW;

	// front to queue
	logic job_push, queue_full;
	job_t push_job;

	// queue to back
	logic job_valid, job_pop;
	job_t head_job;

	// word ram ports
	logic             wr_en, rd_en;
	logic [AddrW-1:0] wr_addr, rd_addr;
	logic [6:0]       wr_data, rd_data;

	// classify bytes, track words, parse the number, store word characters
	ltw_front #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_item (char_item),
		.push      (push),
		.full      (full),
		.queue_full(queue_full),
		.job_push  (job_push),
		.job       (push_job),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// two finished lines at most, one per ram bank
	ltw_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (job_pop),
		.valid   (job_valid),
		.head    (head_job)
	);

	// command and argument characters for both banks
	ltw_ram #(
		.WIDTH(7),
		.DEPTH(Depth)
	) u_word_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// read the words back and emit them, then the summary
	ltw_back #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (head_job),
		.job_pop  (job_pop),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

>>> hdl/ltw_ram.sv
module ltw_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 128,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/ltw_front.sv
module ltw_front #(
	parameter int MAX_WORD_LEN = ltw_pkg::MAX_WORD_LEN_DEF,
	localparam int IdxW = $clog2(MAX_WORD_LEN),
	localparam int AddrW = IdxW + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ltw_pkg::in_item_t char_item,
	input  logic             push,
	output logic             full,
	input  logic             queue_full,
	output logic             job_push,
	output ltw_pkg::job_t    job,
	output logic             wr_en,
	output logic [AddrW-1:0] wr_addr,
	output logic [6:0]       wr_data
);

	import ltw_pkg::*;

	// line state
	logic             bank_q, bank_d;
	logic [LEN_W-1:0] cmd_len_q, cmd_len_d;
	logic [LEN_W-1:0] arg_len_q, arg_len_d;
	logic [2:0]       words_q, words_d;
	logic             in_word_q, in_word_d;
	logic             slash_q, slash_d;
	logic             ended_q, ended_d;
	logic             err_ascii_q, err_ascii_d;
	logic             err_many_q, err_many_d;
	logic             err_long_q, err_long_d;
	logic             err_notint_q, err_notint_d;
	sign_t            sign_q, sign_d;
	logic             digits_q, digits_d;
	logic [31:0]      mag_q, mag_d;

	// byte held back after a lone slash
	logic             replay_valid_q;
	in_item_t         replay_q;

	logic       take, op_valid, set_replay, do_content, do_line_end;
	in_item_t   op;
	logic [7:0] cc;
	logic       space, first;
	logic [2:0] w_new;
	logic [35:0] mag_next;
	status_t    status;
	logic [30:0] number;

	assign full     = replay_valid_q || queue_full;
	assign take     = push && !full;
	assign op_valid = replay_valid_q || take;
	assign op       = replay_valid_q ? replay_q : char_item;

	// route the item: comment start, zero byte, held slash, line end
	always_comb begin
		cc          = op.char_byte;
		do_content  = 1'b0;
		set_replay  = 1'b0;
		do_line_end = 1'b0;
		slash_d     = slash_q;
		ended_d     = ended_q;
		if (op_valid) begin
			if (!op.end_of_line) begin
				if (!ended_q) begin
					if (slash_q) begin
						slash_d = 1'b0;
						if (op.char_byte == CH_SLASH) begin
							ended_d = 1'b1;
						end else begin
							cc         = CH_SLASH;
							do_content = 1'b1;
							set_replay = 1'b1;
						end
					end else if (op.char_byte == CH_NUL) begin
						ended_d = 1'b1;
					end else if (op.char_byte == CH_SLASH) begin
						slash_d = 1'b1;
					end else begin
						do_content = 1'b1;
					end
				end
			end else if (slash_q && !ended_q) begin
				slash_d    = 1'b0;
				cc         = CH_SLASH;
				do_content = 1'b1;
				set_replay = 1'b1;
			end else begin
				do_line_end = 1'b1;
			end
		end
	end

	assign space    = (cc == CH_SPACE) || (cc inside {[CH_TAB:CH_CR]});
	assign first    = !in_word_q;
	assign w_new    = (first && words_q < 3'd4) ? words_q + 3'd1 : words_q;
	assign mag_next = 36'(mag_q) * 36'(RADIX) + 36'(cc - CH_ZERO);

	// at most one content character per cycle; line end clears the line state and flips the bank
	always_comb begin
		bank_d       = bank_q;
		cmd_len_d    = cmd_len_q;
		arg_len_d    = arg_len_q;
		words_d      = words_q;
		in_word_d    = in_word_q;
		err_ascii_d  = err_ascii_q;
		err_many_d   = err_many_q;
		err_long_d   = err_long_q;
		err_notint_d = err_notint_q;
		sign_d       = sign_q;
		digits_d     = digits_q;
		mag_d        = mag_q;
		wr_en        = 1'b0;
		wr_addr      = {bank_q, 1'b0, cmd_len_q[IdxW-1:0]};
		wr_data      = cc[6:0];
		if (do_content) begin
			if (cc[7]) begin
				err_ascii_d = 1'b1;
			end
			if (space) begin
				in_word_d = 1'b0;
			end else begin
				in_word_d = 1'b1;
				words_d   = w_new;
				if (first && w_new == 3'd4) begin
					err_many_d = 1'b1;
				end
				if (!cc[7]) begin
					case (w_new)
						3'd1: begin
							if (cmd_len_q >= LEN_W'(MAX_WORD_LEN)) begin
								err_long_d = 1'b1;
							end else begin
								wr_en     = 1'b1;
								cmd_len_d = cmd_len_q + LEN_W'(1);
							end
						end
						3'd2: begin
							wr_addr = {bank_q, 1'b1, arg_len_q[IdxW-1:0]};
							if (arg_len_q >= LEN_W'(MAX_WORD_LEN)) begin
								err_long_d = 1'b1;
							end else begin
								wr_en     = 1'b1;
								arg_len_d = arg_len_q + LEN_W'(1);
							end
						end
						3'd3: begin
							if (first && (cc == CH_PLUS || cc == CH_MINUS)) begin
								sign_d = (cc == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
							end else if (cc inside {[CH_ZERO:CH_NINE]}) begin
								mag_d    = (mag_next[35:32] != 4'd0) ? MAG_SAT : mag_next[31:0];
								digits_d = 1'b1;
							end else begin
								err_notint_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end else if (do_line_end) begin
			bank_d       = !bank_q;
			cmd_len_d    = '0;
			arg_len_d    = '0;
			words_d      = '0;
			in_word_d    = 1'b0;
			err_ascii_d  = 1'b0;
			err_many_d   = 1'b0;
			err_long_d   = 1'b0;
			err_notint_d = 1'b0;
			sign_d       = SIGN_NONE;
			digits_d     = 1'b0;
			mag_d        = '0;
		end
	end

	// line summary, errors ranked non-ascii, too many words, too long, not an integer, range, negative
	always_comb begin
		status = ST_OK;
		number = '0;
		if (err_ascii_q) begin
			status = ST_NON_ASCII;
		end else if (err_many_q) begin
			status = ST_TOO_MANY;
		end else if (err_long_q) begin
			status = ST_TOO_LONG;
		end else if (words_q == 3'd3) begin
			if (err_notint_q || !digits_q) begin
				status = ST_NOT_INT;
			end else if (sign_q == SIGN_MINUS) begin
				if (mag_q > NEG_TOP) begin
					status = ST_RANGE;
				end else if (mag_q != '0) begin
					status = ST_NEGATIVE;
				end
			end else if (mag_q > INT_TOP) begin
				status = ST_RANGE;
			end else begin
				number = mag_q[30:0];
			end
		end
	end

	assign job_push       = do_line_end;
	assign job.bank       = bank_q;
	assign job.cmd_len    = (status == ST_OK) ? cmd_len_q : '0;
	assign job.arg_len    = (status == ST_OK) ? arg_len_q : '0;
	assign job.status     = status;
	assign job.word_count = (words_q > 3'd3) ? 2'd3 : words_q[1:0];
	assign job.number     = number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q         <= 1'b0;
			cmd_len_q      <= '0;
			arg_len_q      <= '0;
			words_q        <= '0;
			in_word_q      <= 1'b0;
			slash_q        <= 1'b0;
			ended_q        <= 1'b0;
			err_ascii_q    <= 1'b0;
			err_many_q     <= 1'b0;
			err_long_q     <= 1'b0;
			err_notint_q   <= 1'b0;
			sign_q         <= SIGN_NONE;
			digits_q       <= 1'b0;
			mag_q          <= '0;
			replay_valid_q <= 1'b0;
		end else begin
			bank_q         <= bank_d;
			cmd_len_q      <= cmd_len_d;
			arg_len_q      <= arg_len_d;
			words_q        <= words_d;
			in_word_q      <= in_word_d;
			slash_q        <= do_line_end ? 1'b0 : slash_d;
			ended_q        <= do_line_end ? 1'b0 : ended_d;
			err_ascii_q    <= err_ascii_d;
			err_many_q     <= err_many_d;
			err_long_q     <= err_long_d;
			err_notint_q   <= err_notint_d;
			sign_q         <= sign_d;
			digits_q       <= digits_d;
			mag_q          <= mag_d;
			replay_valid_q <= set_replay;
		end
	end

	always_ff @(posedge clk) begin
		if (set_replay) begin
			replay_q <= op;
		end
	end

	a_replay_no_slash: assert property (@(posedge clk) disable iff (!arst_n)
		replay_valid_q |-> !slash_q)
		else $error("held byte replayed while a slash is still pending");

endmodule

>>> hdl/ltw_job_queue.sv
module ltw_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ltw_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output ltw_pkg::job_t head
);

	import ltw_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("line job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("line job popped from an empty queue");

endmodule

>>> hdl/ltw_back.sv
module ltw_back #(
	parameter int MAX_WORD_LEN = ltw_pkg::MAX_WORD_LEN_DEF,
	localparam int IdxW = $clog2(MAX_WORD_LEN),
	localparam int AddrW = IdxW + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  ltw_pkg::job_t      job,
	output logic               job_pop,
	output logic               rd_en,
	output logic [AddrW-1:0]   rd_addr,
	input  logic [6:0]         rd_data,
	output ltw_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	import ltw_pkg::*;

	back_state_t      state_q, state_d;
	logic             sel_q, sel_d;
	logic [LEN_W-1:0] idx_q, idx_d, idx_inc, cur_len;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             slot_free, load_char, load_sum;

	assign slot_free = !out_valid_q || pop;
	assign idx_inc   = idx_q + LEN_W'(1);
	assign cur_len   = sel_q ? job.arg_len : job.cmd_len;
	assign rd_addr   = {job.bank, sel_q, idx_q[IdxW-1:0]};
	assign result    = out_q;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			sel_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			idx_q   <= idx_d;
		end
	end

	// command characters, then argument characters, then the summary
	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		idx_d     = idx_q;
		rd_en     = 1'b0;
		load_char = 1'b0;
		load_sum  = 1'b0;
		job_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					idx_d = '0;
					if (job.cmd_len != '0) begin
						sel_d   = 1'b0;
						state_d = BK_READ;
					end else if (job.arg_len != '0) begin
						sel_d   = 1'b1;
						state_d = BK_READ;
					end else begin
						state_d = BK_SUM;
					end
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_WAIT;
			end
			BK_WAIT: begin
				if (slot_free) begin
					load_char = 1'b1;
					idx_d     = idx_inc;
					state_d   = BK_READ;
					if (idx_inc == cur_len) begin
						if (!sel_q && job.arg_len != '0) begin
							sel_d = 1'b1;
							idx_d = '0;
						end else begin
							state_d = BK_SUM;
						end
					end
				end
			end
			BK_SUM: begin
				if (slot_free) begin
					load_sum = 1'b1;
					job_pop  = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_char || load_sum) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_char) begin
			out_q.kind       <= sel_q ? KIND_ARG : KIND_CMD;
			out_q.char_out   <= rd_data;
			out_q.status     <= ST_OK;
			out_q.word_count <= '0;
			out_q.number     <= '0;
			out_q.last       <= 1'b0;
		end else if (load_sum) begin
			out_q.kind       <= KIND_SUM;
			out_q.char_out   <= '0;
			out_q.status     <= job.status;
			out_q.word_count <= job.word_count;
			out_q.number     <= job.number;
			out_q.last       <= 1'b1;
		end
	end

	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_IDLE |-> job_valid)
		else $error("emission running without a queued line");

endmodule

>>> bench/line_result_checker.sv
module line_result_checker #(
	parameter int MAX_WORD_LEN = ltw_pkg::MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ltw_pkg::in_item_t  char_item,
	input  logic               push,
	input  logic               full,
	input  ltw_pkg::out_item_t result,
	input  logic               empty,
	input  logic               pop,
	output int                 mismatches,
	output int                 awaited
);
	import ltw_pkg::*;

	localparam int BUF_DEPTH = 31;
	// error flag bit positions
	localparam int ERR_ASCII  = 0;
	localparam int ERR_MANY   = 1;
	localparam int ERR_LONG   = 2;
	localparam int ERR_NOTINT = 3;

	logic [6:0]  cmd_word [BUF_DEPTH];
	logic [6:0]  arg_word [BUF_DEPTH];
	int          cmd_len;
	int          arg_len;
	int          word_no;
	logic        in_word;
	logic        slash_held;
	logic        line_done;
	logic        got_digit;
	logic [3:0]  err;
	sign_t       sign;
	logic [31:0] mag;
	int          bad;
	out_item_t   token_queue [$];

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic clear_line();
		cmd_len = 0;
		arg_len = 0;
		word_no = 0;
		in_word = 1'b0;
		slash_held = 1'b0;
		line_done = 1'b0;
		got_digit = 1'b0;
		err = '0;
		sign = SIGN_NONE;
		mag = '0;
	endtask

	task automatic word_char(logic [7:0] c);
		logic        first;
		logic [63:0] grown;
		first = 1'b0;
		if (c[7])
			err[ERR_ASCII] = 1'b1;
		if (is_blank(c)) begin
			in_word = 1'b0;
			return;
		end
		if (!in_word) begin
			in_word = 1'b1;
			first = 1'b1;
			if (word_no < 4)
				word_no++;
			if (word_no == 4)
				err[ERR_MANY] = 1'b1;
		end
		if (c[7])
			return;
		case (word_no)
			1: begin
				if (cmd_len >= MAX_WORD_LEN || cmd_len >= BUF_DEPTH) begin
					err[ERR_LONG] = 1'b1;
				end else begin
					cmd_word[cmd_len] = c[6:0];
					cmd_len++;
				end
			end
			2: begin
				if (arg_len >= MAX_WORD_LEN || arg_len >= BUF_DEPTH) begin
					err[ERR_LONG] = 1'b1;
				end else begin
					arg_word[arg_len] = c[6:0];
					arg_len++;
				end
			end
			3: begin
				if (first && (c == CH_PLUS || c == CH_MINUS)) begin
					sign = (c == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					grown = 64'(mag) * RADIX + 64'(c - CH_ZERO);
					mag = (grown > 64'(MAG_SAT)) ? MAG_SAT : grown[31:0];
					got_digit = 1'b1;
				end else begin
					err[ERR_NOTINT] = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic take_byte(logic [7:0] c);
		if (line_done)
			return;
		if (slash_held) begin
			slash_held = 1'b0;
			if (c == CH_SLASH) begin
				line_done = 1'b1;
				return;
			end
			word_char(CH_SLASH);
		end
		if (c == CH_NUL)
			line_done = 1'b1;
		else if (c == CH_SLASH)
			slash_held = 1'b1;
		else
			word_char(c);
	endtask

	task automatic close_line();
		status_t     st;
		logic [1:0]  count;
		logic [30:0] value;
		out_item_t   t;
		int          i;
		if (slash_held && !line_done)
			word_char(CH_SLASH);
		count = (word_no > 3) ? 2'd3 : 2'(word_no);
		st = ST_OK;
		value = '0;
		if (err[ERR_ASCII]) begin
			st = ST_NON_ASCII;
		end else if (err[ERR_MANY]) begin
			st = ST_TOO_MANY;
		end else if (err[ERR_LONG]) begin
			st = ST_TOO_LONG;
		end else if (word_no == 3) begin
			if (err[ERR_NOTINT] || !got_digit) begin
				st = ST_NOT_INT;
			end else if (sign == SIGN_MINUS) begin
				if (mag > NEG_TOP)
					st = ST_RANGE;
				else if (mag != 0)
					st = ST_NEGATIVE;
			end else if (mag > INT_TOP) begin
				st = ST_RANGE;
			end else begin
				value = mag[30:0];
			end
		end
		if (st == ST_OK) begin
			for (i = 0; i < cmd_len; i++) begin
				t = '0;
				t.kind = KIND_CMD;
				t.char_out = cmd_word[i];
				token_queue.push_back(t);
			end
			for (i = 0; i < arg_len; i++) begin
				t = '0;
				t.kind = KIND_ARG;
				t.char_out = arg_word[i];
				token_queue.push_back(t);
			end
		end
		t = '0;
		t.kind = KIND_SUM;
		t.status = st;
		t.word_count = count;
		t.number = value;
		t.last = 1'b1;
		token_queue.push_back(t);
		clear_line();
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (token_queue.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("unexpected result: kind %0d char %h status %0d count %0d number %0d last %0b",
					got.kind, got.char_out, got.status, got.word_count, got.number, got.last);
			return;
		end
		want = token_queue.pop_front();
		if (got.kind !== want.kind || got.char_out !== want.char_out
				|| got.status !== want.status || got.word_count !== want.word_count
				|| got.number !== want.number || got.last !== want.last) begin
			bad++;
			if (bad <= 10) begin
				$display("expected: kind %0d char %h status %0d count %0d number %0d last %0b",
					want.kind, want.char_out, want.status, want.word_count, want.number,
					want.last);
				$display("actual:   kind %0d char %h status %0d count %0d number %0d last %0b",
					got.kind, got.char_out, got.status, got.word_count, got.number, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			token_queue.delete();
			bad = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (pop && !empty)
				check_result(result);
			if (push && !full) begin
				if (char_item.end_of_line)
					close_line();
				else
					take_byte(char_item.char_byte);
			end
			mismatches <= bad;
			awaited <= token_queue.size();
		end
	end

endmodule

>>> bench/tb_line_tokenizer_three_words_core.sv
module tb_line_tokenizer_three_words_core;
	import ltw_pkg::*;

	// stop offering new lines once this many items went in
	localparam int ITEM_TARGET  = 500;
	// generous ceiling: every item and result with its longest wait, many times over
	localparam int CYCLE_LIMIT  = 400000;
	// long receiver hold-off so two finished lines pile up and push sees full
	localparam int RX_HOLD      = 200;
	// quiet cycles after the last result, catches stray extra results
	localparam int DRAIN_CYCLES = 100;

	logic      clk;
	logic      arst_n;
	in_item_t  char_item;
	logic      push;
	logic      full;
	out_item_t result;
	logic      empty;
	logic      pop;

	int        mismatches;
	int        awaited;
	int        sent;
	int        cycles;
	bit        tx_steady;
	bit        rx_steady;
	bit        rx_hold_req;

	line_tokenizer_three_words_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_item (char_item),
		.push      (push),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// watches both channels, predicts every line and compares the results
	line_result_checker #(
		.MAX_WORD_LEN (MAX_WORD_LEN_DEF)
	) tokens_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_item  (char_item),
		.push       (push),
		.full       (full),
		.result     (result),
		.empty      (empty),
		.pop        (pop),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("line_tokenizer_three_words_core: mismatch");
		$finish;
	end

	// one item into the block: optional idle gap, then hold push until it is taken
	task automatic send_item(logic [7:0] c, logic eol);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(9);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_item <= '{char_byte: c, end_of_line: eol};
		push <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
	endtask

	// bytes of one line, then the end-of-line item with a random ignored byte
	task automatic send_line(ref logic [7:0] q[$]);
		foreach (q[i])
			send_item(q[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic add_text(ref logic [7:0] q[$], input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endtask

	task automatic send_text(string s);
		logic [7:0] q[$];
		add_text(q, s);
		send_line(q);
	endtask

	// one to three whitespace bytes, every C whitespace code reachable
	task automatic add_blank(ref logic [7:0] q[$]);
		int r;
		repeat ($urandom_range(1, 3)) begin
			r = $urandom_range(5);
			q.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
		end
	endtask

	// printable word bytes, now and then a lone slash
	task automatic add_word(ref logic [7:0] q[$], input int len);
		logic [7:0] c;
		repeat (len) begin
			if ($urandom_range(19) == 0) begin
				c = CH_SLASH;
			end else begin
				do c = 8'($urandom_range(33, 126)); while (c == CH_SLASH);
			end
			q.push_back(c);
		end
	endtask

	task automatic add_noise(ref logic [7:0] q[$]);
		repeat ($urandom_range(6))
			q.push_back(8'($urandom_range(255)));
	endtask

	// third word: small values, full 32-bit span, int edges, overlong digit runs, junk
	function automatic string number_text();
		string s;
		int    r;
		s = "";
		r = $urandom_range(9);
		if (r == 9) begin
			case ($urandom_range(3))
				0: s = ($urandom_range(1) == 0) ? "+" : "-";
				1: s = {$sformatf("%0d", $urandom_range(99)), "x"};
				2: s = "1-2";
				default: s = "+-3";
			endcase
			return s;
		end
		case ($urandom_range(4))
			0: s = "+";
			1: s = "-";
			default: s = "";
		endcase
		case (r)
			0, 1, 2, 3: s = {s, $sformatf("%0d", $urandom_range(999))};
			4, 5: s = {s, $sformatf("%0d", $urandom())};
			6, 7: begin
				case ($urandom_range(5))
					0: s = {s, "2147483647"};
					1: s = {s, "2147483648"};
					2: s = {s, "2147483649"};
					3: s = {s, "4294967295"};
					4: s = {s, "4294967296"};
					default: s = {s, "0"};
				endcase
			end
			default: begin
				repeat ($urandom_range(11, 16))
					s = {s, $sformatf("%0d", $urandom_range(9))};
			end
		endcase
		return s;
	endfunction

	// mostly well-formed lines with random content, some broken, some pure noise
	task automatic build_line(ref logic [7:0] q[$]);
		int r;
		int nw;
		int w;
		q.delete();
		r = $urandom_range(99);
		if (r >= 85) begin
			repeat ($urandom_range(10))
				q.push_back(8'($urandom_range(255)));
			return;
		end
		case ($urandom_range(9))
			0: nw = 0;
			1: nw = 1;
			2: nw = 2;
			default: nw = 3;
		endcase
		if ($urandom_range(3) == 0)
			add_blank(q);
		for (w = 1; w <= nw; w++) begin
			if (w > 1)
				add_blank(q);
			if (w == 3)
				add_text(q, number_text());
			else
				add_word(q, ($urandom_range(14) == 0) ? $urandom_range(29, 33)
					: $urandom_range(1, 6));
		end
		// broken lines: an extra word or a non-ascii byte somewhere
		if (r >= 70) begin
			if (r < 78) begin
				add_blank(q);
				add_word(q, $urandom_range(1, 4));
			end else begin
				q.insert($urandom_range(q.size()), 8'($urandom_range(128, 255)));
			end
		end
		// tail: whitespace, comment, held slash at line end, or zero byte
		case ($urandom_range(9))
			0: add_blank(q);
			1: begin
				add_text(q, "//");
				add_noise(q);
			end
			2: q.push_back(CH_SLASH);
			3: begin
				q.push_back(CH_NUL);
				add_noise(q);
			end
			default: begin
			end
		endcase
	endtask

	// short three-word line, used to pile up finished lines quickly
	task automatic short_line(ref logic [7:0] q[$]);
		q.delete();
		add_word(q, $urandom_range(1, 3));
		add_blank(q);
		add_word(q, $urandom_range(1, 3));
		add_blank(q);
		add_text(q, $sformatf("%0d", $urandom_range(99)));
	endtask

	// receiver: random pop gaps, steady stretches, and one long hold-off on request
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				rx_hold_req = 1'b0;
			end
			gap = rx_steady ? 0 : $urandom_range(9);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// sender and verdict
	initial begin
		logic [7:0] line_bytes[$];
		int         line_no;
		arst_n = 1'b0;
		push = 1'b0;
		char_item = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 1'b0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blank line
		line_bytes.delete();
		send_line(line_bytes);
		// slash inside a word, minus zero accepted
		send_text("x/ y -0");
		// fourth word
		send_text("a b c d");
		// third word not a number
		send_text("a b c");
		// negative value, then a comment
		send_text("a b -5//z");
		// lone slash still held at line end
		send_text("a/");
		// zero byte cuts the line
		line_bytes = '{8'h70, CH_NUL, 8'h71};
		send_line(line_bytes);
		// top byte value, non-ascii
		line_bytes = '{8'hFF};
		send_line(line_bytes);

		line_no = 0;
		while (sent < ITEM_TARGET) begin
			// switch idling style every few lines
			if (line_no % 8 == 0) begin
				tx_steady = ($urandom_range(3) == 0);
				rx_steady = ($urandom_range(3) == 0);
			end
			if (line_no == 6) begin
				// receiver stalls while lines keep coming, the block fills up
				rx_hold_req = 1'b1;
				tx_steady = 1'b1;
				repeat (12) begin
					short_line(line_bytes);
					send_line(line_bytes);
				end
				tx_steady = 1'b0;
			end else if (line_no == 14) begin
				// sender waits until every result of earlier lines is out
				push <= 1'b0;
				@(posedge clk);
				while (awaited != 0) @(posedge clk);
			end
			build_line(line_bytes);
			send_line(line_bytes);
			line_no++;
		end
		push <= 1'b0;

		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("line_tokenizer_three_words_core: match");
		else
			$display("line_tokenizer_three_words_core: mismatch");
		$finish;
	end

endmodule

>>> files.f
hdl/ltw_pkg.sv
hdl/ltw_ram.sv
hdl/ltw_front.sv
hdl/ltw_job_queue.sv
hdl/ltw_back.sv
hdl/line_tokenizer_three_words_core.sv
bench/line_result_checker.sv
bench/tb_line_tokenizer_three_words_core.sv
